@@ hdl/microwire_eeprom_master_defines.svh @@
// Assertion macros for the Microwire EEPROM master checker.
// No dependencies; included by the checker file only.
`ifndef MICROWIRE_EEPROM_MASTER_DEFINES_SVH
`define MICROWIRE_EEPROM_MASTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MWEM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MWEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mwem_pkg.sv @@
// Shared types and constants for the Microwire EEPROM master.
// No dependencies; used by every module of the block.
package mwem_pkg;

    localparam int ADDRESS_BITS_DEF = 7;
    localparam int DATA_BITS_DEF    = 8;
    localparam int ADDRESS_BITS_MAX = 10;
    localparam int DATA_BITS_MAX    = 16;

    // start bit + opcode + address + data, left aligned in the job word
    localparam int CMD_W   = 3 + ADDRESS_BITS_MAX + DATA_BITS_MAX;
    localparam int NBITS_W = $clog2(CMD_W + 1);

    localparam int ADDR_W      = 7;
    localparam int WDATA_W     = 8;
    localparam int RB_W        = 8;
    localparam int POLL_W      = 16;
    localparam int OP_W        = 3;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;
    localparam int M_FIELDS_W  = 12;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [POLL_W-1:0] POLL_LIMIT_RST = 16'd1000;
    localparam logic              REG_POLL_LIMIT = 1'b0;

    localparam logic [1:0] OPC_READ  = 2'b10;
    localparam logic [1:0] OPC_WRITE = 2'b01;
    localparam logic [1:0] OPC_EWDS  = 2'b00;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_WEN    = 3'd2,
        OP_WDIS   = 3'd3,
        OP_SAMPLE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ACT_DRIVE  = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_DONE   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EARLY   = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    // what follows the serial bits of a job
    typedef enum logic [1:0] {
        TAIL_SAMPLE = 2'd0,   // one sample request
        TAIL_FINISH = 2'd1,   // cs low, then done beat
        TAIL_WRITE  = 2'd2    // cs low, cs high, sample request
    } t_tail;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_RD_DUMMY = 7'b0000010,
        PH_RD_BITS  = 7'b0000100,
        PH_WR_DUMMY = 7'b0001000,
        PH_WR_CHK1  = 7'b0010000,
        PH_WR_CHK2  = 7'b0100000,
        PH_WR_POLL  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [CMD_W-1:0]   bits;
        logic [NBITS_W-1:0] nbits;
        t_tail              tail;
        logic [RB_W-1:0]    rb;
        t_status            st;
    } t_job;

    typedef struct packed {
        t_action         action;
        logic            cs;
        logic            dout;
        logic [RB_W-1:0] rb;
        t_status         st;
        logic            last;
    } t_beat;

endpackage

@@ hdl/mwem_cfg.sv @@
// APB register file of the Microwire EEPROM master: the ready poll limit.
// Depends on mwem_pkg.
module mwem_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mwem_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mwem_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mwem_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [mwem_pkg::POLL_W-1:0]     o_poll_limit
);

    logic [mwem_pkg::POLL_W-1:0] r_poll_limit;
    logic                        sel_poll;

    assign pready   = 1'b1;
    assign sel_poll = (paddr[2] == mwem_pkg::REG_POLL_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= mwem_pkg::POLL_LIMIT_RST;
        end else if (psel && penable && pwrite && pready && sel_poll) begin
            r_poll_limit <= pwdata[mwem_pkg::POLL_W-1:0];
        end
    end

    assign prdata = sel_poll ? mwem_pkg::APB_DATA_W'(r_poll_limit) : '0;
    assign o_poll_limit = r_poll_limit;

endmodule

@@ hdl/mwem_ctrl.sv @@
// Protocol state of the Microwire EEPROM master: turns each accepted item that has
// beats into a beat job for the emitter and advances the phase. Depends on mwem_pkg.
module mwem_ctrl #(
    parameter int ADDRESS_BITS = mwem_pkg::ADDRESS_BITS_DEF,
    parameter int DATA_BITS    = mwem_pkg::DATA_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [mwem_pkg::OP_W-1:0]      i_op,
    input  logic [mwem_pkg::ADDR_W-1:0]    i_addr,
    input  logic [mwem_pkg::WDATA_W-1:0]   i_wdata,
    input  logic                           i_line,
    input  logic [mwem_pkg::POLL_W-1:0]    i_poll_limit,
    output logic                           o_load,
    output mwem_pkg::t_job                 o_job
);

    localparam int RD_LEN = 3 + ADDRESS_BITS;
    localparam int WR_LEN = RD_LEN + DATA_BITS;
    localparam int BC_W   = $clog2(DATA_BITS + 1);
    localparam logic [ADDRESS_BITS-1:0] EWEN_FIELD = {2'b11, {(ADDRESS_BITS-2){1'b0}}};

    mwem_pkg::t_phase            r_phase, n_phase;
    logic [BC_W-1:0]             r_bit_count, n_bit_count;
    logic [DATA_BITS-1:0]        r_read_shift, n_read_shift;
    logic [mwem_pkg::POLL_W-1:0] r_poll_count, n_poll_count;

    logic [ADDRESS_BITS-1:0] adr;
    logic [DATA_BITS-1:0]    wd;
    logic                    has_beats;
    mwem_pkg::t_job          job;

    assign adr = ADDRESS_BITS'(i_addr);
    assign wd  = DATA_BITS'(i_wdata);

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_read_shift = r_read_shift;
        n_poll_count = r_poll_count;
        has_beats    = 1'b0;
        job.bits     = '0;
        job.nbits    = '0;
        job.tail     = mwem_pkg::TAIL_SAMPLE;
        job.rb       = '0;
        job.st       = mwem_pkg::ST_OK;

        // operations five to seven fall through both arms and are dropped
        if (i_op <= mwem_pkg::OP_WDIS) begin
            if (r_phase == mwem_pkg::PH_IDLE) begin
                has_beats = 1'b1;
                unique case (i_op)
                    mwem_pkg::OP_READ: begin
                        job.bits  = mwem_pkg::CMD_W'({1'b1, mwem_pkg::OPC_READ, adr})
                                    << (mwem_pkg::CMD_W - RD_LEN);
                        job.nbits = mwem_pkg::NBITS_W'(RD_LEN);
                        n_bit_count  = '0;
                        n_read_shift = '0;
                        n_phase      = mwem_pkg::PH_RD_DUMMY;
                    end
                    mwem_pkg::OP_WRITE: begin
                        job.bits  = mwem_pkg::CMD_W'({1'b1, mwem_pkg::OPC_WRITE, adr, wd})
                                    << (mwem_pkg::CMD_W - WR_LEN);
                        job.nbits = mwem_pkg::NBITS_W'(WR_LEN);
                        job.tail  = mwem_pkg::TAIL_WRITE;
                        n_phase   = mwem_pkg::PH_WR_DUMMY;
                    end
                    mwem_pkg::OP_WEN: begin
                        job.bits  = mwem_pkg::CMD_W'({1'b1, mwem_pkg::OPC_EWDS, EWEN_FIELD})
                                    << (mwem_pkg::CMD_W - RD_LEN);
                        job.nbits = mwem_pkg::NBITS_W'(RD_LEN);
                        job.tail  = mwem_pkg::TAIL_FINISH;
                    end
                    default: begin
                        job.bits  = mwem_pkg::CMD_W'({1'b1, mwem_pkg::OPC_EWDS})
                                    << (mwem_pkg::CMD_W - 3);
                        job.nbits = mwem_pkg::NBITS_W'(RD_LEN);
                        job.tail  = mwem_pkg::TAIL_FINISH;
                    end
                endcase
            end
        end else if (i_op == mwem_pkg::OP_SAMPLE) begin
            unique case (r_phase)
                mwem_pkg::PH_RD_DUMMY: begin
                    has_beats = 1'b1;
                    n_phase   = mwem_pkg::PH_RD_BITS;
                end
                mwem_pkg::PH_RD_BITS: begin
                    has_beats    = 1'b1;
                    n_read_shift = {r_read_shift[DATA_BITS-2:0], i_line};
                    n_bit_count  = r_bit_count + BC_W'(1);
                    if (n_bit_count >= BC_W'(DATA_BITS)) begin
                        job.tail = mwem_pkg::TAIL_FINISH;
                        job.rb   = n_read_shift[mwem_pkg::RB_W-1:0];
                        n_phase  = mwem_pkg::PH_IDLE;
                    end
                end
                mwem_pkg::PH_WR_DUMMY: begin
                    has_beats = 1'b1;
                    n_phase   = mwem_pkg::PH_WR_CHK1;
                end
                mwem_pkg::PH_WR_CHK1, mwem_pkg::PH_WR_CHK2: begin
                    has_beats = 1'b1;
                    if (i_line && (r_phase == mwem_pkg::PH_WR_CHK1)) begin
                        n_phase = mwem_pkg::PH_WR_CHK2;
                    end else if (i_line) begin
                        // ready already before the part went busy
                        job.tail = mwem_pkg::TAIL_FINISH;
                        job.st   = mwem_pkg::ST_EARLY;
                        n_phase  = mwem_pkg::PH_IDLE;
                    end else begin
                        n_poll_count = i_poll_limit;
                        if (i_poll_limit == '0) begin
                            job.tail = mwem_pkg::TAIL_FINISH;
                            job.st   = mwem_pkg::ST_TIMEOUT;
                            n_phase  = mwem_pkg::PH_IDLE;
                        end else begin
                            n_phase = mwem_pkg::PH_WR_POLL;
                        end
                    end
                end
                mwem_pkg::PH_WR_POLL: begin
                    has_beats = 1'b1;
                    if (i_line) begin
                        job.tail = mwem_pkg::TAIL_FINISH;
                        n_phase  = mwem_pkg::PH_IDLE;
                    end else begin
                        n_poll_count = r_poll_count - mwem_pkg::POLL_W'(1);
                        if (n_poll_count == '0) begin
                            job.tail = mwem_pkg::TAIL_FINISH;
                            job.st   = mwem_pkg::ST_TIMEOUT;
                            n_phase  = mwem_pkg::PH_IDLE;
                        end
                    end
                end
                default: begin
                    n_phase = mwem_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= mwem_pkg::PH_IDLE;
            r_bit_count  <= '0;
            r_read_shift <= '0;
            r_poll_count <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_read_shift <= n_read_shift;
            r_poll_count <= n_poll_count;
        end
    end

    assign o_load = i_accept && has_beats;
    assign o_job  = job;

endmodule

@@ hdl/mwem_emit.sv @@
// Beat sequencer of the Microwire EEPROM master: plays one job out as pin,
// sample and done beats, one per cycle while the output is ready. Depends on mwem_pkg.
module mwem_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  mwem_pkg::t_job  i_job,
    input  logic            i_m_tready,
    output logic            o_busy,
    output logic            o_ready,
    output mwem_pkg::t_beat o_beat
);

    logic                         r_busy;
    logic [mwem_pkg::CMD_W-1:0]   r_bits;
    logic [mwem_pkg::NBITS_W-1:0] r_left;
    logic [1:0]                   r_tidx;
    mwem_pkg::t_tail              r_tail;
    logic [mwem_pkg::RB_W-1:0]    r_rb;
    mwem_pkg::t_status            r_st;

    mwem_pkg::t_beat beat;
    logic            take;

    always_comb begin
        beat.action = mwem_pkg::ACT_DRIVE;
        beat.cs     = 1'b0;
        beat.dout   = 1'b0;
        beat.rb     = '0;
        beat.st     = mwem_pkg::ST_OK;
        beat.last   = 1'b0;
        if (r_left != '0) begin
            beat.cs   = 1'b1;
            beat.dout = r_bits[mwem_pkg::CMD_W-1];
        end else begin
            unique case (r_tail)
                mwem_pkg::TAIL_FINISH: begin
                    if (r_tidx != 2'd0) begin
                        beat.action = mwem_pkg::ACT_DONE;
                        beat.rb     = r_rb;
                        beat.st     = r_st;
                        beat.last   = 1'b1;
                    end
                end
                mwem_pkg::TAIL_WRITE: begin
                    // cs low, cs high, then ask for the first sample
                    beat.cs = (r_tidx == 2'd1);
                    if (r_tidx == 2'd2) begin
                        beat.action = mwem_pkg::ACT_SAMPLE;
                        beat.last   = 1'b1;
                    end
                end
                default: begin
                    beat.action = mwem_pkg::ACT_SAMPLE;
                    beat.last   = 1'b1;
                end
            endcase
        end
    end

    assign take    = r_busy && i_m_tready;
    assign o_ready = !r_busy || (take && beat.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_load) begin
            r_busy <= 1'b1;
        end else if (take && beat.last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bits <= i_job.bits;
            r_left <= i_job.nbits;
            r_tidx <= 2'd0;
            r_tail <= i_job.tail;
            r_rb   <= i_job.rb;
            r_st   <= i_job.st;
        end else if (take) begin
            if (r_left != '0) begin
                r_bits <= r_bits << 1;
                r_left <= r_left - mwem_pkg::NBITS_W'(1);
            end else begin
                r_tidx <= r_tidx + 2'd1;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_beat = beat;

endmodule

@@ hdl/microwire_eeprom_master.sv @@
// Microwire (x8) EEPROM master: read, write, write enable and write
// disable commands in, pin and sample beats out, sampled data-in bits back in.
// Each accepted item is worked out combinationally into a job, and the job is played
// out one beat per cycle while i_m_tready is high: a command gives 3 + ADDRESS_BITS
// serial bit beats (plus DATA_BITS more for a write) and then its tail (up to
// 3 + ADDRESS_BITS + DATA_BITS + 3 = 21 beats for a write at the defaults), a sample
// gives one or two beats, and an ignored item gives none.
// The next item is accepted in the cycle the last beat of the current one is taken,
// or at once when no beats are pending, so the rate is set by the beat sequencer.
// Register 0 (byte address 0) is poll_limit, 16 bits, reset 1000.
// Depends on mwem_pkg, mwem_cfg, mwem_ctrl and mwem_emit.
module microwire_eeprom_master #(
    parameter int ADDRESS_BITS = mwem_pkg::ADDRESS_BITS_DEF,
    parameter int DATA_BITS    = mwem_pkg::DATA_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [6:0] address, [14:7] write_data, [15] line_in
    input  logic [mwem_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // [2:0] operation
    input  logic [mwem_pkg::OP_W-1:0]        i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [0] chip_select, [1] data_out, [9:2] read_byte, [11:10] status, [15:12] zero
    output logic [mwem_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // [1:0] action
    output logic [1:0]                       o_m_tuser,
    output logic                             o_m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mwem_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mwem_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mwem_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    logic                        accept;
    logic                        load;
    logic                        busy;
    logic                        ready;
    logic [mwem_pkg::POLL_W-1:0] poll_limit;
    mwem_pkg::t_job              job;
    mwem_pkg::t_beat             beat;

    mwem_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_poll_limit (poll_limit)
    );

    assign accept = i_s_tvalid && ready;

    mwem_ctrl #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .DATA_BITS    (DATA_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_op         (i_s_tuser),
        .i_addr       (i_s_tdata[6:0]),
        .i_wdata      (i_s_tdata[14:7]),
        .i_line       (i_s_tdata[15]),
        .i_poll_limit (poll_limit),
        .o_load       (load),
        .o_job        (job)
    );

    mwem_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_job      (job),
        .i_m_tready (i_m_tready),
        .o_busy     (busy),
        .o_ready    (ready),
        .o_beat     (beat)
    );

    assign o_s_tready = ready;
    assign o_m_tvalid = busy;
    assign o_m_tuser  = beat.action;
    assign o_m_tlast  = beat.last;
    assign o_m_tdata  = {{(mwem_pkg::M_TDATA_W - mwem_pkg::M_FIELDS_W){1'b0}},
                         beat.st, beat.rb, beat.dout, beat.cs};

endmodule

@@ hdl/mwem_checker.sv @@
// Port-level checks for the Microwire EEPROM master, bound to the top level.
// Depends on mwem_pkg and microwire_eeprom_master_defines.svh.
`include "microwire_eeprom_master_defines.svh"

module mwem_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [mwem_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic [1:0]                     o_m_tuser,
    input logic                           o_m_tlast
);

    // a done beat always closes the item's run
    `MWEM_ASSERT_NOW(a_done_is_last, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == mwem_pkg::ACT_DONE), o_m_tlast, "done beat without tlast")

    // only pin beats carry pin levels
    `MWEM_ASSERT_NOW(a_pins_quiet, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != mwem_pkg::ACT_DRIVE), o_m_tdata[1:0] == 2'b00, "pin levels on a non-pin beat")

    // nothing pending means the input side is open
    `MWEM_ASSERT_NOW(a_idle_ready, i_clk, i_rst_n, !o_m_tvalid, o_s_tready, "idle but not ready")

    // last beat taken and no new item: output goes quiet
    `MWEM_ASSERT_NEXT(a_drain, i_clk, i_rst_n, o_m_tvalid && i_m_tready && o_m_tlast && !(i_s_tvalid && o_s_tready), !o_m_tvalid, "beat after the last one")

endmodule

bind microwire_eeprom_master mwem_checker u_mwem_checker (.*);
